// ===== design/rgb565_hsl_color_classifier_defines.svh =====
// ----------------------------------------------------------------------------
// rgb565 hsl color classifier assertion macros
// concurrent check helpers, empty when built for synthesis
// ----------------------------------------------------------------------------
`ifndef RGB565_HSL_COLOR_CLASSIFIER_DEFINES_SVH
`define RGB565_HSL_COLOR_CLASSIFIER_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RHCC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rhcc check failed");
// implication after a fixed number of cycles
`define RHCC_ASSERT_DELAY(label, clk, rst, ante, n, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
      else $error("rhcc check failed");
`else
`define RHCC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define RHCC_ASSERT_DELAY(label, clk, rst, ante, n, cons)
`endif
`endif

// ===== design/rhcc_pkg.sv =====
// ----------------------------------------------------------------------------
// rhcc_pkg
// shared types, register map and helpers of the rgb565 hsl classifier
// ----------------------------------------------------------------------------
package rhcc_pkg;

   // color classes
   typedef enum logic [2:0] {
      CLASS_UNKNOWN = 3'd0,
      CLASS_WHITE   = 3'd1,
      CLASS_BLACK   = 3'd2,
      CLASS_GRAY    = 3'd3,
      CLASS_RED     = 3'd4,
      CLASS_YELLOW  = 3'd5,
      CLASS_GREEN   = 3'd6,
      CLASS_BLUE    = 3'd7
   } rhcc_class_type;

   // register indexes
   localparam int NUM_REGS = 8;
   localparam logic [2:0] REG_LUM_DARK   = 3'd0;
   localparam logic [2:0] REG_LUM_BRIGHT = 3'd1;
   localparam logic [2:0] REG_SAT_GRAY   = 3'd2;
   localparam logic [2:0] REG_HUE_RED    = 3'd3;
   localparam logic [2:0] REG_HUE_YELLOW = 3'd4;
   localparam logic [2:0] REG_HUE_GREEN  = 3'd5;
   localparam logic [2:0] REG_BLUE_START = 3'd6;
   localparam logic [2:0] REG_BLUE_END   = 3'd7;

   localparam logic [7:0] CFG_RESET [NUM_REGS] = '{
      8'd45, 8'd120, 8'd20, 8'd35, 8'd50, 8'd90, 8'd130, 8'd180
   };

   // fixed constants of the color math
   localparam logic [7:0]  HSL_MAX       = 8'd240;
   localparam logic [7:0]  RED_WRAP      = 8'd220;
   localparam logic [7:0]  HUE_BASE_RED  = 8'd0;
   localparam logic [7:0]  HUE_BASE_GRN  = 8'd80;
   localparam logic [7:0]  HUE_BASE_BLU  = 8'd160;
   localparam logic [7:0]  HUE_BASE_WRAP = 8'd240;
   localparam logic [15:0] HUE_SCALE     = 16'd40;
   localparam logic [15:0] SAT_SCALE     = 16'd240;
   localparam logic [8:0]  SAT_TWICE_MAX = 9'd510;
   localparam logic [8:0]  SUM_LUM_ZERO  = 9'd2;    // sum at or below gives l == 0
   localparam logic [8:0]  SUM_LUM_MID   = 9'd257;  // sum at or below gives l <= 120
   // l = sum * 8 / 17 as (sum * 30848) >> 16, exact for sum <= 504
   localparam logic [23:0] LUM_RECIP     = 24'd30848;

   // one lane of the restoring divider
   typedef struct packed {
      logic [15:0] rem;
      logic [8:0]  divisor;
      logic [7:0]  quot;
   } rhcc_div_lane_type;

   // item data carried beside the divider
   typedef struct packed {
      logic [7:0] hue_base;
      logic       hue_neg;
      logic [7:0] luminance;
   } rhcc_side_type;

   // two quotient bits of a restoring division, highest bit first
   function automatic rhcc_div_lane_type div_pair(input rhcc_div_lane_type a,
                                                  input logic [2:0] hi_bit);
      rhcc_div_lane_type r;
      logic [15:0] trial_hi;
      logic [15:0] trial_lo;
      logic [2:0]  lo_bit;
      r        = a;
      lo_bit   = hi_bit - 3'd1;
      trial_hi = {7'd0, a.divisor} << hi_bit;
      if (r.rem >= trial_hi) begin
         r.rem          = r.rem - trial_hi;
         r.quot[hi_bit] = 1'b1;
      end
      trial_lo = {7'd0, a.divisor} << lo_bit;
      if (r.rem >= trial_lo) begin
         r.rem          = r.rem - trial_lo;
         r.quot[lo_bit] = 1'b1;
      end
      return r;
   endfunction

endpackage

// ===== design/rhcc_divider.sv =====
// ----------------------------------------------------------------------------
// rhcc_divider
// two-lane pipelined restoring divider, 8-bit quotient, two bits per stage
// ----------------------------------------------------------------------------
`include "rgb565_hsl_color_classifier_defines.svh"

module rhcc_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  rhcc_pkg::rhcc_div_lane_type in_hue,
   input  rhcc_pkg::rhcc_div_lane_type in_sat,
   input  rhcc_pkg::rhcc_side_type    in_side,
   output logic                       out_valid,
   output logic [7:0]                 out_hue_quot,
   output logic [7:0]                 out_sat_quot,
   output rhcc_pkg::rhcc_side_type    out_side
);

   localparam int STAGES = 4;

   rhcc_pkg::rhcc_div_lane_type hue_in  [STAGES];
   rhcc_pkg::rhcc_div_lane_type sat_in  [STAGES];
   rhcc_pkg::rhcc_div_lane_type hue_ff  [STAGES];
   rhcc_pkg::rhcc_div_lane_type sat_ff  [STAGES];
   rhcc_pkg::rhcc_side_type     side_ff [STAGES];
   logic [STAGES-1:0]           valid_ff;

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      localparam logic [2:0] HI = 3'(7 - 2 * k);

      if (k == 0) begin : g_first
         assign hue_in[k] = rhcc_pkg::div_pair(in_hue, HI);
         assign sat_in[k] = rhcc_pkg::div_pair(in_sat, HI);
         always_ff @(posedge clock) begin
            side_ff[k] <= in_side;
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else begin
               valid_ff[k] <= in_valid;
            end
         end
      end else begin : g_next
         assign hue_in[k] = rhcc_pkg::div_pair(hue_ff[k-1], HI);
         assign sat_in[k] = rhcc_pkg::div_pair(sat_ff[k-1], HI);
         always_ff @(posedge clock) begin
            side_ff[k] <= side_ff[k-1];
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end

      always_ff @(posedge clock) begin
         hue_ff[k] <= hue_in[k];
         sat_ff[k] <= sat_in[k];
      end
   end

   assign out_valid    = valid_ff[STAGES-1];
   assign out_hue_quot = hue_ff[STAGES-1].quot;
   assign out_sat_quot = sat_ff[STAGES-1].quot;
   assign out_side     = side_ff[STAGES-1];

   // checks
   `RHCC_ASSERT_DELAY(a_div_latency, clock, reset, in_valid, 4, out_valid)
   `RHCC_ASSERT_IMPL(a_div_hue_rem, clock, reset, out_valid, {7'd0, hue_ff[STAGES-1].divisor} > hue_ff[STAGES-1].rem)
   `RHCC_ASSERT_IMPL(a_div_sat_rem, clock, reset, out_valid, {7'd0, sat_ff[STAGES-1].divisor} > sat_ff[STAGES-1].rem)

endmodule

// ===== design/rgb565_hsl_color_classifier.sv =====
// ----------------------------------------------------------------------------
// rgb565_hsl_color_classifier
// rgb565 pixel to hsl (0..240 scale) and threshold color class
// ----------------------------------------------------------------------------
//
//  channel   ports                                    beat taken when
//  --------  ---------------------------------------  ---------------------------------
//  request   start, busy, req_pixel                   start high and busy low
//  response  rsp_strobe, rsp_color_class, rsp_hue,    rsp_strobe high (one cycle only)
//            rsp_saturation, rsp_luminance
//  config    psel, penable, pwrite, paddr, pwdata,    psel, penable, pwrite, pready high
//            prdata, pready
//
//  one pixel per clock: busy is tied low, the pipeline never stops
//  a pixel taken at an edge passes the stage 1 and stage 2 registers, the divider
//  stages and the response register before its result beat shows on rsp_strobe
//  depth is set by the 4-stage divider: two quotient bits per stage on each lane
//  reset clears the valid chain and loads the threshold defaults
//  the receiver cannot hold results off, so there is no backpressure path
//
`include "rgb565_hsl_color_classifier_defines.svh"

module rgb565_hsl_color_classifier (
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_pixel,
   // response
   output logic        rsp_strobe,
   output logic [2:0]  rsp_color_class,
   output logic [7:0]  rsp_hue,
   output logic [7:0]  rsp_saturation,
   output logic [7:0]  rsp_luminance,
   // config
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // ---------------------------------------------------------------------
   // config registers
   // ---------------------------------------------------------------------
   logic [7:0] cfg_ff [rhcc_pkg::NUM_REGS];
   logic       cfg_write;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;
   assign prdata    = {24'd0, cfg_ff[paddr[4:2]]};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rhcc_pkg::NUM_REGS; i++) begin
            cfg_ff[i] <= rhcc_pkg::CFG_RESET[i];
         end
      end else if (cfg_write) begin
         cfg_ff[paddr[4:2]] <= pwdata[7:0];
      end
   end

   // never stalls
   assign busy = 1'b0;

   // ---------------------------------------------------------------------
   // stage 1: unpack, max/min, hue channel select, saturation divisor
   // ---------------------------------------------------------------------
   logic       accept;
   logic [7:0] red8, grn8, blu8;
   logic [7:0] mx, mn, diff;
   logic [8:0] sum;

   logic       s1_valid_ff;
   logic [7:0] s1_hue_base_in,  s1_hue_base_ff;
   logic       s1_hue_neg_in,   s1_hue_neg_ff;
   logic [7:0] s1_hue_mag_in,   s1_hue_mag_ff;
   logic [8:0] s1_hue_div_in,   s1_hue_div_ff;
   logic [7:0] s1_sat_d_in,     s1_sat_d_ff;
   logic [8:0] s1_sat_div_in,   s1_sat_div_ff;
   logic [8:0] s1_sum_ff;

   assign accept = start && !busy;
   // widen channels, low bits zero
   assign red8 = {req_pixel[15:11], 3'b000};
   assign grn8 = {req_pixel[10:5], 2'b00};
   assign blu8 = {req_pixel[4:0], 3'b000};

   always_comb begin
      mx = red8;
      if (grn8 > mx) mx = grn8;
      if (blu8 > mx) mx = blu8;
      mn = red8;
      if (grn8 < mn) mn = grn8;
      if (blu8 < mn) mn = blu8;
   end

   assign diff = mx - mn;
   assign sum  = {1'b0, mx} + {1'b0, mn};

   // hue: signed 40*x/d becomes a base, a sign and a magnitude
   always_comb begin
      s1_hue_base_in = rhcc_pkg::HUE_BASE_RED;
      s1_hue_neg_in  = 1'b0;
      s1_hue_mag_in  = 8'd0;
      s1_hue_div_in  = {1'b0, diff};
      if (diff == 8'd0) begin
         // gray pixel: zero numerator over a safe divisor gives hue 0
         s1_hue_div_in = 9'd1;
      end else if (mx == red8) begin
         if (grn8 >= blu8) begin
            s1_hue_mag_in = grn8 - blu8;
         end else begin
            s1_hue_base_in = rhcc_pkg::HUE_BASE_WRAP;
            s1_hue_neg_in  = 1'b1;
            s1_hue_mag_in  = blu8 - grn8;
         end
      end else if (mx == grn8) begin
         s1_hue_base_in = rhcc_pkg::HUE_BASE_GRN;
         if (blu8 >= red8) begin
            s1_hue_mag_in = blu8 - red8;
         end else begin
            s1_hue_neg_in = 1'b1;
            s1_hue_mag_in = red8 - blu8;
         end
      end else begin
         s1_hue_base_in = rhcc_pkg::HUE_BASE_BLU;
         if (red8 >= grn8) begin
            s1_hue_mag_in = red8 - grn8;
         end else begin
            s1_hue_neg_in = 1'b1;
            s1_hue_mag_in = grn8 - red8;
         end
      end
   end

   // saturation: zero when gray or when luminance is zero, else pick the divisor
   // by luminance range, decided straight from the channel sum
   always_comb begin
      if (diff == 8'd0 || sum <= rhcc_pkg::SUM_LUM_ZERO) begin
         s1_sat_d_in   = 8'd0;
         s1_sat_div_in = 9'd1;
      end else if (sum <= rhcc_pkg::SUM_LUM_MID) begin
         s1_sat_d_in   = diff;
         s1_sat_div_in = sum;
      end else begin
         s1_sat_d_in   = diff;
         s1_sat_div_in = rhcc_pkg::SAT_TWICE_MAX - sum;
      end
   end

   always_ff @(posedge clock) begin
      s1_hue_base_ff <= s1_hue_base_in;
      s1_hue_neg_ff  <= s1_hue_neg_in;
      s1_hue_mag_ff  <= s1_hue_mag_in;
      s1_hue_div_ff  <= s1_hue_div_in;
      s1_sat_d_ff    <= s1_sat_d_in;
      s1_sat_div_ff  <= s1_sat_div_in;
      s1_sum_ff      <= sum;
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   // ---------------------------------------------------------------------
   // stage 2: scale numerators, luminance by reciprocal multiply
   // ---------------------------------------------------------------------
   logic [23:0] lum_prod;
   logic        s2_valid_ff;
   rhcc_pkg::rhcc_div_lane_type s2_hue_in,  s2_hue_ff;
   rhcc_pkg::rhcc_div_lane_type s2_sat_in,  s2_sat_ff;
   rhcc_pkg::rhcc_side_type     s2_side_in, s2_side_ff;

   // l = (sum*240/255)/2 = sum*8/17
   assign lum_prod = {15'd0, s1_sum_ff} * rhcc_pkg::LUM_RECIP;

   always_comb begin
      s2_hue_in.rem     = {8'd0, s1_hue_mag_ff} * rhcc_pkg::HUE_SCALE;
      s2_hue_in.divisor = s1_hue_div_ff;
      s2_hue_in.quot    = 8'd0;
      s2_sat_in.rem     = {8'd0, s1_sat_d_ff} * rhcc_pkg::SAT_SCALE;
      s2_sat_in.divisor = s1_sat_div_ff;
      s2_sat_in.quot    = 8'd0;
      s2_side_in.hue_base  = s1_hue_base_ff;
      s2_side_in.hue_neg   = s1_hue_neg_ff;
      s2_side_in.luminance = lum_prod[23:16];
   end

   always_ff @(posedge clock) begin
      s2_hue_ff  <= s2_hue_in;
      s2_sat_ff  <= s2_sat_in;
      s2_side_ff <= s2_side_in;
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // ---------------------------------------------------------------------
   // stages 3..6: hue and saturation quotients
   // ---------------------------------------------------------------------
   logic                    div_valid;
   logic [7:0]              div_hue_quot;
   logic [7:0]              div_sat_quot;
   rhcc_pkg::rhcc_side_type div_side;

   rhcc_divider u_divider (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (s2_valid_ff),
      .in_hue       (s2_hue_ff),
      .in_sat       (s2_sat_ff),
      .in_side      (s2_side_ff),
      .out_valid    (div_valid),
      .out_hue_quot (div_hue_quot),
      .out_sat_quot (div_sat_quot),
      .out_side     (div_side)
   );

   // ---------------------------------------------------------------------
   // stage 7: apply sign and base, clamp, classify
   // ---------------------------------------------------------------------
   logic signed [9:0]        hue_raw;
   logic [7:0]               hue_val, sat_val, lum_val;
   logic                     lum_mid;
   rhcc_pkg::rhcc_class_type class_in;

   logic                     rsp_strobe_ff;
   rhcc_pkg::rhcc_class_type rsp_class_ff;
   logic [7:0]               rsp_hue_ff, rsp_sat_ff, rsp_lum_ff;

   always_comb begin
      if (div_side.hue_neg) begin
         hue_raw = $signed({2'b00, div_side.hue_base}) - $signed({2'b00, div_hue_quot});
      end else begin
         hue_raw = $signed({2'b00, div_side.hue_base}) + $signed({2'b00, div_hue_quot});
      end
      if (hue_raw < 10'sd0) begin
         hue_val = 8'd0;
      end else if (hue_raw > $signed({2'b00, rhcc_pkg::HSL_MAX})) begin
         hue_val = rhcc_pkg::HSL_MAX;
      end else begin
         hue_val = hue_raw[7:0];
      end
      sat_val = (div_sat_quot > rhcc_pkg::HSL_MAX) ? rhcc_pkg::HSL_MAX : div_sat_quot;
      lum_val = (div_side.luminance > rhcc_pkg::HSL_MAX) ? rhcc_pkg::HSL_MAX
                                                          : div_side.luminance;
   end

   assign lum_mid = (lum_val > cfg_ff[rhcc_pkg::REG_LUM_DARK]) &&
                    (lum_val < cfg_ff[rhcc_pkg::REG_LUM_BRIGHT]);

   // later hue bands win over earlier ones
   always_comb begin
      class_in = rhcc_pkg::CLASS_UNKNOWN;
      if (lum_mid) begin
         if (sat_val > cfg_ff[rhcc_pkg::REG_SAT_GRAY]) begin
            if (hue_val < cfg_ff[rhcc_pkg::REG_HUE_RED] || hue_val > rhcc_pkg::RED_WRAP) begin
               class_in = rhcc_pkg::CLASS_RED;
            end
            if (hue_val >= cfg_ff[rhcc_pkg::REG_HUE_RED] &&
                hue_val < cfg_ff[rhcc_pkg::REG_HUE_YELLOW]) begin
               class_in = rhcc_pkg::CLASS_YELLOW;
            end
            if (hue_val >= cfg_ff[rhcc_pkg::REG_HUE_YELLOW] &&
                hue_val < cfg_ff[rhcc_pkg::REG_HUE_GREEN]) begin
               class_in = rhcc_pkg::CLASS_GREEN;
            end
            if (hue_val >= cfg_ff[rhcc_pkg::REG_BLUE_START] &&
                hue_val < cfg_ff[rhcc_pkg::REG_BLUE_END]) begin
               class_in = rhcc_pkg::CLASS_BLUE;
            end
         end else begin
            class_in = rhcc_pkg::CLASS_GRAY;
         end
      end else if (lum_val >= cfg_ff[rhcc_pkg::REG_LUM_BRIGHT]) begin
         class_in = rhcc_pkg::CLASS_WHITE;
      end else begin
         class_in = rhcc_pkg::CLASS_BLACK;
      end
   end

   always_ff @(posedge clock) begin
      rsp_class_ff <= class_in;
      rsp_hue_ff   <= hue_val;
      rsp_sat_ff   <= sat_val;
      rsp_lum_ff   <= lum_val;
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= div_valid;
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_color_class = rsp_class_ff;
   assign rsp_hue         = rsp_hue_ff;
   assign rsp_saturation  = rsp_sat_ff;
   assign rsp_luminance   = rsp_lum_ff;

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------
   `RHCC_ASSERT_DELAY(a_latency, clock, reset, start && !busy, 7, rsp_strobe)
   `RHCC_ASSERT_IMPL(a_hsl_range, clock, reset, rsp_strobe, rsp_hue <= rhcc_pkg::HSL_MAX && rsp_saturation <= rhcc_pkg::HSL_MAX && rsp_luminance <= rhcc_pkg::HSL_MAX)
   `RHCC_ASSERT_IMPL(a_hue_class_sat, clock, reset, rsp_strobe && rsp_color_class[2], rsp_saturation != 8'd0)
   `RHCC_ASSERT_IMPL(a_gray_zero_hue, clock, reset, rsp_strobe && rsp_saturation == 8'd0 && rsp_luminance != 8'd0, rsp_hue == 8'd0)

endmodule

// ===== verif/rgb565_hsl_color_classifier_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb565_hsl_color_classifier_test
// drives rgb565 pixels through the classifier and checks every result beat
// against a local hsl predictor, under several threshold register settings
// ----------------------------------------------------------------------------
module rgb565_hsl_color_classifier_test;

   localparam int LIMIT_CYCLES = 200000;
   // margin waited after the last expected result beat comes back
   localparam int PIPE_DRAIN   = 12;
   // threshold defaults, register i in bits 8*i+7..8*i
   localparam logic [63:0] DEFAULT_THRESH =
      {8'd180, 8'd130, 8'd90, 8'd50, 8'd35, 8'd20, 8'd120, 8'd45};

   // one result beat as the predictor sees it
   typedef struct packed {
      rhcc_pkg::rhcc_class_type color_class;
      logic [7:0]               hue;
      logic [7:0]               saturation;
      logic [7:0]               luminance;
   } hsl_beat_type;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        start     = 1'b0;
   logic        busy;
   logic [15:0] req_pixel = '0;
   logic        rsp_strobe;
   logic [2:0]  rsp_color_class;
   logic [7:0]  rsp_hue;
   logic [7:0]  rsp_saturation;
   logic [7:0]  rsp_luminance;
   logic        psel      = 1'b0;
   logic        penable   = 1'b0;
   logic        pwrite    = 1'b0;
   logic [4:0]  paddr     = '0;
   logic [31:0] pwdata    = '0;
   logic [31:0] prdata;
   logic        pready;

   // local copy of the threshold registers, indexed by register number
   logic [7:0]   thresh [rhcc_pkg::NUM_REGS];
   hsl_beat_type expected_hsl [$];
   int           err_count   = 0;
   int           cycle_count = 0;
   int           burst_left  = 0;

   always #5 clock = ~clock;

   rgb565_hsl_color_classifier u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_pixel       (req_pixel),
      .rsp_strobe      (rsp_strobe),
      .rsp_color_class (rsp_color_class),
      .rsp_hue         (rsp_hue),
      .rsp_saturation  (rsp_saturation),
      .rsp_luminance   (rsp_luminance),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   // ------------------------------------------------------------------------
   // hsl predictor
   // ------------------------------------------------------------------------

   function automatic int clamp_hsl(input int v);
      if (v < 0) return 0;
      if (v > 240) return 240;
      return v;
   endfunction

   function automatic hsl_beat_type predict_hsl(input logic [15:0] px);
      int           r, g, b, mx, mn, d, sum, h, s, l;
      hsl_beat_type res;
      // widen channels to 8 bits, low bits zero
      r = {px[15:11], 3'b000};
      g = {px[10:5], 2'b00};
      b = {px[4:0], 3'b000};
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      d   = mx - mn;
      sum = mx + mn;
      l   = sum * 240 / 255 / 2;
      h   = 0;
      s   = 0;
      if (d != 0) begin
         // red wins ties, then green; int division truncates toward zero
         if (mx == r) begin
            h = 40 * (g - b) / d;
            if (g < b) h = h + 240;
         end else if (mx == g) begin
            h = 40 * (b - r) / d + 80;
         end else begin
            h = 40 * (r - g) / d + 160;
         end
         if (l == 0) s = 0;
         else if (l <= 120) s = d * 240 / sum;
         else s = d * 240 / (510 - sum);
      end
      h = clamp_hsl(h);
      s = clamp_hsl(s);
      l = clamp_hsl(l);
      res.hue         = h[7:0];
      res.saturation  = s[7:0];
      res.luminance   = l[7:0];
      res.color_class = rhcc_pkg::CLASS_UNKNOWN;
      if (l > thresh[rhcc_pkg::REG_LUM_DARK] && l < thresh[rhcc_pkg::REG_LUM_BRIGHT]) begin
         if (s > thresh[rhcc_pkg::REG_SAT_GRAY]) begin
            // later bands overwrite earlier ones
            if (h < thresh[rhcc_pkg::REG_HUE_RED] || h > rhcc_pkg::RED_WRAP)
               res.color_class = rhcc_pkg::CLASS_RED;
            if (h >= thresh[rhcc_pkg::REG_HUE_RED] && h < thresh[rhcc_pkg::REG_HUE_YELLOW])
               res.color_class = rhcc_pkg::CLASS_YELLOW;
            if (h >= thresh[rhcc_pkg::REG_HUE_YELLOW] && h < thresh[rhcc_pkg::REG_HUE_GREEN])
               res.color_class = rhcc_pkg::CLASS_GREEN;
            if (h >= thresh[rhcc_pkg::REG_BLUE_START] && h < thresh[rhcc_pkg::REG_BLUE_END])
               res.color_class = rhcc_pkg::CLASS_BLUE;
         end else begin
            res.color_class = rhcc_pkg::CLASS_GRAY;
         end
      end else if (l >= thresh[rhcc_pkg::REG_LUM_BRIGHT]) begin
         res.color_class = rhcc_pkg::CLASS_WHITE;
      end else begin
         res.color_class = rhcc_pkg::CLASS_BLACK;
      end
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // result checker: every strobe beat is matched to the oldest expectation
   // ------------------------------------------------------------------------

   always @(posedge clock) begin
      hsl_beat_type want;
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("RESULT: ERROR");
         $finish;
      end else if (!reset && rsp_strobe) begin
         if (expected_hsl.size() == 0) begin
            $error("result beat with nothing expected");
            err_count = err_count + 1;
         end else begin
            want = expected_hsl.pop_front();
            if (rsp_color_class !== want.color_class) begin
               $error("color_class mismatch: expected %0d, actual %0d",
                      want.color_class, rsp_color_class);
               err_count = err_count + 1;
            end
            if (rsp_hue !== want.hue) begin
               $error("hue mismatch: expected %0d, actual %0d", want.hue, rsp_hue);
               err_count = err_count + 1;
            end
            if (rsp_saturation !== want.saturation) begin
               $error("saturation mismatch: expected %0d, actual %0d",
                      want.saturation, rsp_saturation);
               err_count = err_count + 1;
            end
            if (rsp_luminance !== want.luminance) begin
               $error("luminance mismatch: expected %0d, actual %0d",
                      want.luminance, rsp_luminance);
               err_count = err_count + 1;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // pixel sender
   // ------------------------------------------------------------------------

   // one pixel beat; bursts of random length, random gaps between them,
   // a quarter of the bursts start with no gap at all
   task automatic send_pixel(input logic [15:0] px);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         repeat (gap) @(negedge clock) start <= 1'b0;
      end
      burst_left = burst_left - 1;
      @(negedge clock);
      start     <= 1'b1;
      req_pixel <= px;
      // beat is taken at the first edge with busy low
      do @(posedge clock); while (busy);
      expected_hsl.push_back(predict_hsl(px));
   endtask

   // stop sending and let every expected beat come back
   task automatic wait_for_results();
      @(negedge clock) start <= 1'b0;
      while (expected_hsl.size() != 0) @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   // pixel mix: uniform, near gray, and one dominant channel
   function automatic logic [15:0] random_pixel();
      int lvl, r5, g6, b5;
      case ($urandom_range(0, 3))
         0: begin
            // near gray: all channels close to one level
            lvl = $urandom_range(0, 31);
            r5  = lvl + $urandom_range(0, 2) - 1;
            g6  = 2 * lvl + $urandom_range(0, 4) - 2;
            b5  = lvl + $urandom_range(0, 2) - 1;
         end
         1: begin
            // one dominant channel, others random
            r5 = $urandom_range(0, 31);
            g6 = $urandom_range(0, 63);
            b5 = $urandom_range(0, 31);
            case ($urandom_range(0, 2))
               0: r5 = $urandom_range(24, 31);
               1: g6 = $urandom_range(48, 63);
               default: b5 = $urandom_range(24, 31);
            endcase
         end
         default: begin
            r5 = $urandom_range(0, 31);
            g6 = $urandom_range(0, 63);
            b5 = $urandom_range(0, 31);
         end
      endcase
      r5 = (r5 < 0) ? 0 : (r5 > 31) ? 31 : r5;
      g6 = (g6 < 0) ? 0 : (g6 > 63) ? 63 : g6;
      b5 = (b5 < 0) ? 0 : (b5 > 31) ? 31 : b5;
      return {r5[4:0], g6[5:0], b5[4:0]};
   endfunction

   task automatic send_random_pixels(input int count);
      repeat (count) send_pixel(random_pixel());
   endtask

   // ------------------------------------------------------------------------
   // register access
   // ------------------------------------------------------------------------

   task automatic csr_write(input logic [2:0] idx, input logic [7:0] val);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {24'd0, val};
      @(negedge clock) penable <= 1'b1;
      do @(posedge clock); while (!pready);
      thresh[idx] = val;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic csr_read(input logic [2:0] idx, output logic [31:0] val);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(negedge clock) penable <= 1'b1;
      do @(posedge clock); while (!pready);
      val = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic check_thresholds();
      logic [31:0] val;
      for (int i = 0; i < rhcc_pkg::NUM_REGS; i++) begin
         csr_read(i[2:0], val);
         if (val[7:0] !== thresh[i]) begin
            $error("csr %0d readback mismatch: expected %0d, actual %0d",
                   i, thresh[i], val[7:0]);
            err_count = err_count + 1;
         end
      end
   endtask

   // only while idle: drain first, then write every register and read back
   task automatic load_thresholds(input logic [63:0] vals);
      wait_for_results();
      for (int i = 0; i < rhcc_pkg::NUM_REGS; i++) csr_write(i[2:0], vals[8*i +: 8]);
      check_thresholds();
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   task automatic test_reset_values();
      check_thresholds();
   endtask

   task automatic test_corner_pixels();
      // channel extremes and pure primaries / secondaries
      send_pixel(16'h0000);   // black, d zero
      send_pixel(16'hffff);   // brightest white
      send_pixel(16'hf800);   // pure red
      send_pixel(16'h07e0);   // pure green
      send_pixel(16'h001f);   // pure blue
      send_pixel(16'hffe0);   // yellow, green just above red, green path
      send_pixel(16'h07ff);   // cyan, lands between green and blue bands
      send_pixel(16'hf81f);   // magenta, red and blue tie
      send_pixel(16'hf802);   // red with a little blue, hue wraps above 220
      send_pixel(16'h0001);   // dimmest blue, luminance close to zero
      send_pixel(16'h0020);   // dimmest green
      send_pixel(16'h0800);   // dimmest red
      // grays at a few levels, hue and saturation stay zero
      send_pixel(16'h8410);
      send_pixel(16'h4208);
      send_pixel(16'hc618);
      // bright tints take the 510 - sum saturation path, the last one is a gray
      send_pixel(16'hfdf7);
      send_pixel(16'hbfff);
      send_pixel(16'hffdf);
      // mid tones near the default band edges
      send_pixel(16'hc300);
      send_pixel(16'h8400);
      send_pixel(16'h0410);
      send_pixel(16'h401f);
      send_pixel(16'h87e0);
      wait_for_results();
   endtask

   task automatic test_threshold_settings();
      logic [63:0] vals;
      // everything zero: nothing is mid luminance, all white
      load_thresholds(64'd0);
      send_random_pixels(50);
      // everything at the top of the range: all black
      load_thresholds({8{8'd240}});
      send_random_pixels(50);
      // wide mid window, gray only at zero saturation, overlapping hue bands overwrite each other
      load_thresholds({8'd240, 8'd0, 8'd240, 8'd0, 8'd0, 8'd0, 8'd240, 8'd0});
      send_random_pixels(60);
      // register values beyond 240 are used as they stand
      load_thresholds({8'd255, 8'd250, 8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0});
      send_random_pixels(60);
      // random settings
      repeat (3) begin
         for (int i = 0; i < rhcc_pkg::NUM_REGS; i++) begin
            vals[8*i +: 8] = $urandom_range(0, 240);
         end
         load_thresholds(vals);
         send_random_pixels(60);
      end
      load_thresholds(DEFAULT_THRESH);
   endtask

   task automatic test_random_stream();
      send_random_pixels(140);
      // sender holds off until the pipeline is empty, then resumes
      wait_for_results();
      send_random_pixels(140);
      wait_for_results();
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------

   initial begin
      for (int i = 0; i < rhcc_pkg::NUM_REGS; i++) thresh[i] = DEFAULT_THRESH[8*i +: 8];
      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      test_reset_values();
      test_corner_pixels();
      test_threshold_settings();
      test_random_stream();
      wait_for_results();
      if (err_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
